FILE: src/xxt_pkg.sv
// ----------------------------------------------------------------------------
// xxt_pkg
// Types and constants shared by the four-word XXTEA cipher pipeline.
// ----------------------------------------------------------------------------
package xxt_pkg;

  localparam int WORD_W      = 32;
  localparam int BLOCK_WORDS = 4;
  localparam int ROUND_COUNT = 19;
  localparam int STAGES      = ROUND_COUNT * BLOCK_WORDS;
  localparam int CFG_IDX_W   = 8;

  typedef logic [WORD_W-1:0]                   word_t;
  typedef logic [BLOCK_WORDS-1:0][WORD_W-1:0]  block_t;
  typedef logic [BLOCK_WORDS-1:0][WORD_W-1:0]  key_t;
  typedef logic [1:0]                          widx_t;
  typedef logic [CFG_IDX_W-1:0]                cfg_idx_t;

  localparam word_t       DELTA        = 32'h9E37_79B9;
  localparam logic [63:0] SUM_PROD     = 64'(DELTA) * 64'(ROUND_COUNT);
  localparam word_t       SUM_DEC_INIT = SUM_PROD[WORD_W-1:0];
  localparam word_t       KEY_RESET    = 32'hFFFF_FFFF;

  // Operation select
  localparam logic CMD_ENCRYPT = 1'b0;
  localparam logic CMD_DECRYPT = 1'b1;

  // Configuration register indexes
  localparam cfg_idx_t REG_KEY0 = 8'd0;
  localparam cfg_idx_t REG_KEY1 = 8'd1;
  localparam cfg_idx_t REG_KEY2 = 8'd2;
  localparam cfg_idx_t REG_KEY3 = 8'd3;

  // Last word step of a round
  localparam widx_t LAST_STEP = 2'd3;

  // Data carried from one cell to the next
  typedef struct packed {
    logic   cmd;
    widx_t  step;
    word_t  sum;
    block_t w;
  } stage_t;

endpackage

FILE: src/xxt_if.sv
// ----------------------------------------------------------------------------
// xxt_if
// Valid/ready channels of the XXTEA cipher: block in, block out, key write.
// ----------------------------------------------------------------------------
interface xxt_in_if;
  logic          valid;
  logic          ready;
  logic          cmd;
  xxt_pkg::word_t word0_in;
  xxt_pkg::word_t word1_in;
  xxt_pkg::word_t word2_in;
  xxt_pkg::word_t word3_in;

  modport source (output valid, cmd, word0_in, word1_in, word2_in, word3_in,
                  input ready);
  modport sink   (input valid, cmd, word0_in, word1_in, word2_in, word3_in,
                  output ready);
endinterface

interface xxt_out_if;
  logic          valid;
  logic          ready;
  xxt_pkg::word_t word0_out;
  xxt_pkg::word_t word1_out;
  xxt_pkg::word_t word2_out;
  xxt_pkg::word_t word3_out;

  modport source (output valid, word0_out, word1_out, word2_out, word3_out,
                  input ready);
  modport sink   (input valid, word0_out, word1_out, word2_out, word3_out,
                  output ready);
endinterface

interface xxt_cfg_if;
  logic              valid;
  logic              ready;
  xxt_pkg::cfg_idx_t index;
  xxt_pkg::word_t    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/xxtea_block4_cipher.sv
// ----------------------------------------------------------------------------
// xxtea_block4_cipher
// XXTEA cipher on 128-bit blocks, 19 rounds, as a chain of word-update cells.
// ----------------------------------------------------------------------------
// Accepts one block every cycle unless the output is stalled, and passes each
// block through 19 rounds of four word updates, one pipeline cell per update,
// the last cell's register being the output register. The command bit travels
// with the block, so encrypt and decrypt beats may be mixed freely. When the
// output is stalled the whole chain holds. The key lives in four registers
// that reset to all ones; write them only while no block is in flight.
// Writes to register indexes above three are ignored.
module xxtea_block4_cipher (
  input  logic       clk,
  input  logic       rst_n,
  xxt_in_if.sink     in_ch,
  xxt_out_if.source  out_ch,
  xxt_cfg_if.sink    cfg_ch
);

  xxt_pkg::key_t   key_r;
  xxt_pkg::key_t   key_nxt;
  logic            adv;
  logic            vld [0:xxt_pkg::STAGES];
  xxt_pkg::stage_t stg [0:xxt_pkg::STAGES];

  // Key registers
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    key_nxt = key_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        xxt_pkg::REG_KEY0: key_nxt[0] = cfg_ch.data;
        xxt_pkg::REG_KEY1: key_nxt[1] = cfg_ch.data;
        xxt_pkg::REG_KEY2: key_nxt[2] = cfg_ch.data;
        xxt_pkg::REG_KEY3: key_nxt[3] = cfg_ch.data;
        default:           key_nxt    = key_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= {xxt_pkg::BLOCK_WORDS{xxt_pkg::KEY_RESET}};
    end else begin
      key_r <= key_nxt;
    end
  end

  // Hold the chain only while a finished block waits at the output
  assign adv         = out_ch.ready || !vld[xxt_pkg::STAGES];
  assign in_ch.ready = adv;

  assign vld[0]      = in_ch.valid;
  assign stg[0].cmd  = in_ch.cmd;
  assign stg[0].step = '0;
  assign stg[0].sum  = (in_ch.cmd == xxt_pkg::CMD_DECRYPT) ? xxt_pkg::SUM_DEC_INIT
                                                          : xxt_pkg::DELTA;
  assign stg[0].w[0] = in_ch.word0_in;
  assign stg[0].w[1] = in_ch.word1_in;
  assign stg[0].w[2] = in_ch.word2_in;
  assign stg[0].w[3] = in_ch.word3_in;

  for (genvar i = 0; i < xxt_pkg::STAGES; i++) begin : g_cell
    xxt_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv_i   (adv),
      .key_i   (key_r),
      .valid_i (vld[i]),
      .stage_i (stg[i]),
      .valid_o (vld[i+1]),
      .stage_o (stg[i+1])
    );
  end

  assign out_ch.valid     = vld[xxt_pkg::STAGES];
  assign out_ch.word0_out = stg[xxt_pkg::STAGES].w[0];
  assign out_ch.word1_out = stg[xxt_pkg::STAGES].w[1];
  assign out_ch.word2_out = stg[xxt_pkg::STAGES].w[2];
  assign out_ch.word3_out = stg[xxt_pkg::STAGES].w[3];

endmodule

FILE: src/xxt_cell.sv
// ----------------------------------------------------------------------------
// xxt_cell
// One word update of XXTEA: mixes a word with its neighbors and the key,
// then registers the block for the next cell.
// ----------------------------------------------------------------------------
module xxt_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv_i,
  input  xxt_pkg::key_t   key_i,
  input  logic            valid_i,
  input  xxt_pkg::stage_t stage_i,
  output logic            valid_o,
  output xxt_pkg::stage_t stage_o
);

  logic            valid_r;
  xxt_pkg::stage_t stage_r;
  xxt_pkg::stage_t stage_nxt;

  xxt_pkg::widx_t p;
  xxt_pkg::widx_t e;
  xxt_pkg::widx_t kidx;
  xxt_pkg::word_t z;
  xxt_pkg::word_t y;
  xxt_pkg::word_t mix_a;
  xxt_pkg::word_t mix_b;
  xxt_pkg::word_t mix;
  xxt_pkg::word_t cur;

  // Decryption walks the words from the top down
  assign p    = (stage_i.cmd == xxt_pkg::CMD_DECRYPT) ? ~stage_i.step : stage_i.step;
  assign e    = stage_i.sum[3:2];
  assign kidx = p ^ e;
  assign z    = stage_i.w[p - 2'd1];
  assign y    = stage_i.w[p + 2'd1];
  assign cur  = stage_i.w[p];

  assign mix_a = ((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4));
  assign mix_b = (stage_i.sum ^ y) + (key_i[kidx] ^ z);
  assign mix   = mix_a ^ mix_b;

  always_comb begin
    stage_nxt      = stage_i;
    stage_nxt.step = stage_i.step + 2'd1;
    if (stage_i.cmd == xxt_pkg::CMD_DECRYPT) begin
      stage_nxt.w[p] = cur - mix;
    end else begin
      stage_nxt.w[p] = cur + mix;
    end
    // Advance the round sum after the last word of the round
    if (stage_i.step == xxt_pkg::LAST_STEP) begin
      if (stage_i.cmd == xxt_pkg::CMD_DECRYPT) begin
        stage_nxt.sum = stage_i.sum - xxt_pkg::DELTA;
      end else begin
        stage_nxt.sum = stage_i.sum + xxt_pkg::DELTA;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv_i) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_i) begin
      stage_r <= stage_nxt;
    end
  end

  assign valid_o = valid_r;
  assign stage_o = stage_r;

endmodule
